>>> hw/rtl/gcs_pkg.sv
// Shared constants, codes and types for the graph adjacency store.
package gcs_pkg;

   localparam int MAX_NODES_DEF   = 256;
   localparam int MAX_EDGES_DEF   = 1024;
   localparam int WEIGHT_BITS_DEF = 32;
   localparam int SUM_W           = 48;

   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_REMOVE = 3'd1;
   localparam logic [2:0] ACT_WEIGHT = 3'd2;
   localparam logic [2:0] ACT_DEGREE = 3'd3;
   localparam logic [2:0] ACT_OFFSET = 3'd4;
   localparam logic [2:0] ACT_SLOT   = 3'd5;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_RANGE = 2'd1;
   localparam logic [1:0] STS_ZERO  = 2'd2;
   localparam logic [1:0] STS_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ALU_ADD_W,
      ALU_ADD_S,
      ALU_SUB_F
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [SUM_W:0]   a;
      logic [SUM_W:0]   b;
   } alu_req_type;

endpackage

>>> hw/rtl/graph_csr_store_unit.sv
// Top level of the graph adjacency store: sequencer, memories and port registers.
//
// Usage: one request item on req_* (valid/ready) gives exactly one response item on
// rsp_* (valid/ready). node_count is written on csr_* while the block is idle.
// Adds are kept in a sorted, duplicate-merged pending list (insertion walk over the
// list entries). The first query after adds builds the adjacency layout: clear of
// the offset table, degree count per edge, prefix sum over the nodes, slot scatter
// per edge. An add after a build first reloads live edges from the slots. Queries
// on a built store read the offset table and, for node queries, scan the node's
// adjacency range. All steps share one slot memory and one saturating adder.
// One item is processed at a time; req_ready is high while the sequencer is idle,
// also while a finished response waits in the output register. If the receiver
// stalls, the next item runs to completion and then waits for the output register.
// Reset (synchronous, active high) empties the store, sets node_count to 256 and
// drops any pending response. The memories need no clearing pass.
module graph_csr_store_unit #(
   parameter int MAX_NODES   = gcs_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES   = gcs_pkg::MAX_EDGES_DEF,
   parameter int WEIGHT_BITS = gcs_pkg::WEIGHT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_node_a,
   input  logic [7:0]  req_node_b,
   input  logic [31:0] req_weight,
   input  logic [10:0] req_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [47:0] rsp_value,
   output logic [7:0]  rsp_neighbor,
   output logic        rsp_slot_live,
   output logic [10:0] rsp_edge_count,
   output logic [47:0] rsp_total_weight,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_node_count
);

   localparam int SW   = gcs_pkg::SUM_W;
   localparam int W    = WEIGHT_BITS;
   localparam int NW   = $clog2(MAX_NODES);
   localparam int OW   = $clog2(MAX_NODES + 1);
   localparam int SC   = 2 * MAX_EDGES;
   localparam int SAW  = $clog2(SC);
   localparam int CW   = $clog2(SC + 1);
   localparam int LAW  = $clog2(MAX_EDGES);
   localparam int LCW  = $clog2(MAX_EDGES + 1);
   localparam int PW   = (CW > OW) ? CW : OW;
   localparam int IXW  = (PW > 11) ? PW : 11;
   localparam int LEW  = 2 * NW + W;
   localparam int SEW  = 1 + NW + W;
   localparam logic [SW-1:0] WMAX48 = SW'(((SW+1)'(1) << W) - (SW+1)'(1));

   localparam logic [5:0] S_IDLE    = 6'd0;
   localparam logic [5:0] S_DISP    = 6'd1;
   localparam logic [5:0] S_CLR     = 6'd2;
   localparam logic [5:0] S_CNT_RD  = 6'd3;
   localparam logic [5:0] S_CNT_WT  = 6'd4;
   localparam logic [5:0] S_CNT_U   = 6'd5;
   localparam logic [5:0] S_CNT_V   = 6'd6;
   localparam logic [5:0] S_PFX_RD  = 6'd7;
   localparam logic [5:0] S_PFX_WR  = 6'd8;
   localparam logic [5:0] S_SC_RD   = 6'd9;
   localparam logic [5:0] S_SC_WT   = 6'd10;
   localparam logic [5:0] S_SC_U    = 6'd11;
   localparam logic [5:0] S_SC_V    = 6'd12;
   localparam logic [5:0] S_BLD_END = 6'd13;
   localparam logic [5:0] S_Q_START = 6'd14;
   localparam logic [5:0] S_F_OFF0  = 6'd15;
   localparam logic [5:0] S_F_OFF1  = 6'd16;
   localparam logic [5:0] S_F_OFF2  = 6'd17;
   localparam logic [5:0] S_F_RD    = 6'd18;
   localparam logic [5:0] S_F_CHK   = 6'd19;
   localparam logic [5:0] S_REM_END = 6'd20;
   localparam logic [5:0] S_OF_WT   = 6'd21;
   localparam logic [5:0] S_SL_WT   = 6'd22;
   localparam logic [5:0] S_RL_ST   = 6'd23;
   localparam logic [5:0] S_RL_BND  = 6'd24;
   localparam logic [5:0] S_RL_LOOP = 6'd25;
   localparam logic [5:0] S_RL_CHK  = 6'd26;
   localparam logic [5:0] S_RL_END  = 6'd27;
   localparam logic [5:0] S_AD_CHK0 = 6'd28;
   localparam logic [5:0] S_AD_RD   = 6'd29;
   localparam logic [5:0] S_AD_CHK  = 6'd30;
   localparam logic [5:0] S_FINISH  = 6'd31;

   // memories
   logic [LEW-1:0] list_mem_ff [MAX_EDGES];
   logic [CW-1:0]  off_mem_ff  [MAX_NODES+1];
   logic [CW-1:0]  fill_mem_ff [MAX_NODES+1];
   logic [SEW-1:0] slot_mem_ff [SC];

   logic           list_we, off_we, fill_we, slot_we;
   logic [LAW-1:0] list_wa, list_ra;
   logic [LEW-1:0] list_wd, list_rd_ff;
   logic [OW-1:0]  off_wa, off_ra, fill_wa, fill_ra;
   logic [CW-1:0]  off_wd, off_rd_ff, fill_wd, fill_rd_ff;
   logic [SAW-1:0] slot_wa, slot_ra;
   logic [SEW-1:0] slot_wd, slot_rd_ff;

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem_ff[list_wa] <= list_wd;
      end
      list_rd_ff <= list_mem_ff[list_ra];
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem_ff[off_wa] <= off_wd;
      end
      off_rd_ff <= off_mem_ff[off_ra];
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem_ff[fill_wa] <= fill_wd;
      end
      fill_rd_ff <= fill_mem_ff[fill_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem_ff[slot_wa] <= slot_wd;
      end
      slot_rd_ff <= slot_mem_ff[slot_ra];
   end

   // registers
   logic [5:0]     state_ff, state_in;
   logic [8:0]     node_count_ff, node_count_in;
   logic           built_ff, built_in;
   logic [LCW-1:0] raw_ff, raw_in, len_ff, len_in, live_ff, live_in;
   logic [SW-1:0]  wsum_ff, wsum_in;
   logic [CW-1:0]  total_ff, total_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [2:0]     act_ff, act_in;
   logic [7:0]     a_ff, a_in, b_ff, b_in;
   logic [31:0]    w_ff, w_in;
   logic [10:0]    idx_ff, idx_in;
   logic [PW-1:0]  ptr_ff, ptr_in;
   logic [CW-1:0]  bound_ff, bound_in, pfx_ff, pfx_in;
   logic [NW-1:0]  u_ff, u_in, from_ff, from_in, to_ff, to_in;
   logic [LEW-1:0] edge_ff, edge_in, carry_ff, carry_in;
   logic           ins_ff, ins_in, phase_ff, phase_in;
   logic [W-1:0]   wt_ff, wt_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic           res_found_ff, res_found_in, res_live_ff, res_live_in;
   logic [SW-1:0]  res_value_ff, res_value_in;
   logic [7:0]     res_nb_ff, res_nb_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic           rsp_found_ff, rsp_found_in, rsp_live_ff, rsp_live_in;
   logic [SW-1:0]  rsp_value_ff, rsp_value_in, rsp_total_ff, rsp_total_in;
   logic [7:0]     rsp_nb_ff, rsp_nb_in;
   logic [10:0]    rsp_count_ff, rsp_count_in;

   // shared adder
   gcs_pkg::alu_req_type alu_req;
   logic [SW-1:0]        alu_r;

   gcs_sat_alu #(
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_alu (
      .req    (alu_req),
      .result (alu_r)
   );

   // decoded helpers
   logic [16:0]    nc;
   logic           a_ok, ab_ok;
   logic [NW-1:0]  na, nb;
   logic [SW-1:0]  w48;
   logic [W-1:0]   w_sat;
   logic [NW-1:0]  e_u, e_v, s_node;
   logic [W-1:0]   e_w, s_w;
   logic           s_live;
   logic [NW-1:0]  c_u, c_v;
   logic [W-1:0]   c_w;
   logic [NW-1:0]  g_u, g_v;
   logic [W-1:0]   g_w;

   assign nc    = (17'(node_count_ff) > 17'(MAX_NODES)) ? 17'(MAX_NODES)
                                                        : 17'(node_count_ff);
   assign a_ok  = 17'(a_ff) < nc;
   assign ab_ok = a_ok && (17'(b_ff) < nc);
   assign na    = NW'(a_ff);
   assign nb    = NW'(b_ff);
   assign w48   = SW'(w_ff);
   assign w_sat = (w48 > WMAX48) ? W'(WMAX48) : W'(w48);

   // list read data, latched edge and carry fields
   assign e_u = list_rd_ff[LEW-1 -: NW];
   assign e_v = list_rd_ff[LEW-NW-1 -: NW];
   assign e_w = list_rd_ff[W-1:0];
   assign g_u = edge_ff[LEW-1 -: NW];
   assign g_v = edge_ff[LEW-NW-1 -: NW];
   assign g_w = edge_ff[W-1:0];
   assign c_u = carry_ff[LEW-1 -: NW];
   assign c_v = carry_ff[LEW-NW-1 -: NW];
   assign c_w = carry_ff[W-1:0];
   assign s_live = slot_rd_ff[SEW-1];
   assign s_node = slot_rd_ff[W+NW-1:W];
   assign s_w    = slot_rd_ff[W-1:0];

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // adder operands by state
   always_comb begin
      alu_req.op = gcs_pkg::ALU_ADD_S;
      alu_req.a  = '0;
      alu_req.b  = '0;
      unique case (state_ff)
         S_CNT_WT: begin
            alu_req.a = (SW+1)'(wsum_ff);
            alu_req.b = (SW+1)'(e_w);
         end
         S_F_CHK: begin
            alu_req.a = (SW+1)'(res_value_ff);
            alu_req.b = (s_node == from_ff) ? ((SW+1)'(s_w) << 1) : (SW+1)'(s_w);
         end
         S_REM_END: begin
            alu_req.op = gcs_pkg::ALU_SUB_F;
            alu_req.a  = (SW+1)'(wsum_ff);
            alu_req.b  = (SW+1)'(wt_ff);
         end
         S_AD_CHK: begin
            alu_req.op = gcs_pkg::ALU_ADD_W;
            alu_req.a  = (SW+1)'(e_w);
            alu_req.b  = (SW+1)'(c_w);
         end
         default: begin
            alu_req.op = gcs_pkg::ALU_ADD_S;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      built_in      = built_ff;
      raw_in        = raw_ff;
      len_in        = len_ff;
      live_in       = live_ff;
      wsum_in       = wsum_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      act_in        = act_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      bound_in      = bound_ff;
      pfx_in        = pfx_ff;
      u_in          = u_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      edge_in       = edge_ff;
      carry_in      = carry_ff;
      ins_in        = ins_ff;
      phase_in      = phase_ff;
      wt_in         = wt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_live_in   = res_live_ff;
      res_value_in  = res_value_ff;
      res_nb_in     = res_nb_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_nb_in     = rsp_nb_ff;
      rsp_count_in  = rsp_count_ff;

      list_we = 1'b0; list_wa = '0; list_wd = '0; list_ra = '0;
      off_we  = 1'b0; off_wa  = '0; off_wd  = '0; off_ra  = '0;
      fill_we = 1'b0; fill_wa = '0; fill_wd = '0; fill_ra = '0;
      slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;

      if (csr_valid) begin
         node_count_in = csr_node_count;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in        = req_action;
               a_in          = req_node_a;
               b_in          = req_node_b;
               w_in          = req_weight;
               idx_in        = req_index;
               res_status_in = gcs_pkg::STS_OK;
               res_found_in  = 1'b0;
               res_live_in   = 1'b0;
               res_value_in  = '0;
               res_nb_in     = '0;
               state_in      = S_DISP;
            end
         end
         S_DISP: begin
            state_in = built_ff ? S_Q_START : S_CLR;
            ptr_in   = '0;
            case (act_ff)
               gcs_pkg::ACT_ADD: begin
                  if (!ab_ok) begin
                     res_status_in = gcs_pkg::STS_RANGE;
                     state_in      = S_FINISH;
                  end else if (w_ff == '0) begin
                     res_status_in = gcs_pkg::STS_ZERO;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = built_ff ? S_RL_ST : S_AD_CHK0;
                  end
               end
               gcs_pkg::ACT_REMOVE, gcs_pkg::ACT_WEIGHT: begin
                  if (!ab_ok) begin
                     res_status_in = gcs_pkg::STS_RANGE;
                     state_in      = S_FINISH;
                  end
               end
               gcs_pkg::ACT_DEGREE: begin
                  if (!a_ok) begin
                     res_status_in = gcs_pkg::STS_RANGE;
                     state_in      = S_FINISH;
                  end
               end
               gcs_pkg::ACT_OFFSET: begin
                  if (17'(idx_ff) > nc) begin
                     res_status_in = gcs_pkg::STS_RANGE;
                     state_in      = S_FINISH;
                  end
               end
               gcs_pkg::ACT_SLOT: begin
                  state_in = built_ff ? S_Q_START : S_CLR;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // ---- build: clear offsets
         S_CLR: begin
            off_we  = 1'b1;
            off_wa  = OW'(ptr_ff);
            off_wd  = '0;
            wsum_in = '0;
            if (ptr_ff == PW'(MAX_NODES)) begin
               ptr_in   = '0;
               state_in = S_CNT_RD;
            end else begin
               ptr_in = ptr_ff + PW'(1);
            end
         end
         // ---- build: degree count
         S_CNT_RD: begin
            if (ptr_ff == PW'(len_ff)) begin
               fill_we  = 1'b1;
               fill_wa  = '0;
               fill_wd  = '0;
               ptr_in   = PW'(1);
               pfx_in   = '0;
               state_in = S_PFX_RD;
            end else begin
               list_ra  = LAW'(ptr_ff);
               state_in = S_CNT_WT;
            end
         end
         S_CNT_WT: begin
            edge_in  = list_rd_ff;
            wsum_in  = alu_r;
            off_ra   = OW'(e_u) + OW'(1);
            state_in = S_CNT_U;
         end
         S_CNT_U: begin
            off_we = 1'b1;
            off_wa = OW'(g_u) + OW'(1);
            off_wd = off_rd_ff + CW'(1);
            if (g_u != g_v) begin
               off_ra   = OW'(g_v) + OW'(1);
               state_in = S_CNT_V;
            end else begin
               ptr_in   = ptr_ff + PW'(1);
               state_in = S_CNT_RD;
            end
         end
         S_CNT_V: begin
            off_we   = 1'b1;
            off_wa   = OW'(g_v) + OW'(1);
            off_wd   = off_rd_ff + CW'(1);
            ptr_in   = ptr_ff + PW'(1);
            state_in = S_CNT_RD;
         end
         // ---- build: prefix sum into offsets and fill positions
         S_PFX_RD: begin
            off_ra   = OW'(ptr_ff);
            state_in = S_PFX_WR;
         end
         S_PFX_WR: begin
            off_we  = 1'b1;
            off_wa  = OW'(ptr_ff);
            off_wd  = pfx_ff + off_rd_ff;
            fill_we = 1'b1;
            fill_wa = OW'(ptr_ff);
            fill_wd = pfx_ff + off_rd_ff;
            pfx_in  = pfx_ff + off_rd_ff;
            if (ptr_ff == PW'(MAX_NODES)) begin
               total_in = pfx_ff + off_rd_ff;
               ptr_in   = '0;
               state_in = S_SC_RD;
            end else begin
               ptr_in   = ptr_ff + PW'(1);
               state_in = S_PFX_RD;
            end
         end
         // ---- build: scatter slots
         S_SC_RD: begin
            if (ptr_ff == PW'(len_ff)) begin
               state_in = S_BLD_END;
            end else begin
               list_ra  = LAW'(ptr_ff);
               state_in = S_SC_WT;
            end
         end
         S_SC_WT: begin
            edge_in  = list_rd_ff;
            fill_ra  = OW'(e_u);
            state_in = S_SC_U;
         end
         S_SC_U: begin
            fill_we = 1'b1;
            fill_wa = OW'(g_u);
            fill_wd = fill_rd_ff + CW'(1);
            slot_we = 1'b1;
            slot_wa = SAW'(fill_rd_ff);
            slot_wd = {1'b1, g_v, g_w};
            if (g_u != g_v) begin
               fill_ra  = OW'(g_v);
               state_in = S_SC_V;
            end else begin
               ptr_in   = ptr_ff + PW'(1);
               state_in = S_SC_RD;
            end
         end
         S_SC_V: begin
            fill_we  = 1'b1;
            fill_wa  = OW'(g_v);
            fill_wd  = fill_rd_ff + CW'(1);
            slot_we  = 1'b1;
            slot_wa  = SAW'(fill_rd_ff);
            slot_wd  = {1'b1, g_u, g_w};
            ptr_in   = ptr_ff + PW'(1);
            state_in = S_SC_RD;
         end
         S_BLD_END: begin
            built_in = 1'b1;
            live_in  = len_ff;
            raw_in   = '0;
            len_in   = '0;
            state_in = S_Q_START;
         end

         // ---- queries
         S_Q_START: begin
            from_in  = na;
            to_in    = nb;
            phase_in = 1'b0;
            state_in = S_F_OFF0;
            case (act_ff)
               gcs_pkg::ACT_OFFSET: begin
                  off_ra   = OW'(idx_ff);
                  state_in = S_OF_WT;
               end
               gcs_pkg::ACT_SLOT: begin
                  if (IXW'(idx_ff) < IXW'(total_ff)) begin
                     slot_ra  = SAW'(idx_ff);
                     state_in = S_SL_WT;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               default: begin
                  state_in = S_F_OFF0;
               end
            endcase
         end
         S_F_OFF0: begin
            off_ra   = OW'(from_ff);
            state_in = S_F_OFF1;
         end
         S_F_OFF1: begin
            ptr_in   = PW'(off_rd_ff);
            off_ra   = OW'(from_ff) + OW'(1);
            state_in = S_F_OFF2;
         end
         S_F_OFF2: begin
            bound_in = off_rd_ff;
            state_in = S_F_RD;
         end
         S_F_RD: begin
            if (ptr_ff == PW'(bound_ff)) begin
               state_in = phase_ff ? S_REM_END : S_FINISH;
            end else begin
               slot_ra  = SAW'(ptr_ff);
               state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            ptr_in   = ptr_ff + PW'(1);
            state_in = S_F_RD;
            if (act_ff == gcs_pkg::ACT_DEGREE) begin
               if (s_live) begin
                  res_value_in = alu_r;
               end
            end else if (s_live && s_node == to_ff) begin
               if (act_ff == gcs_pkg::ACT_WEIGHT) begin
                  res_value_in = SW'(s_w);
                  res_found_in = 1'b1;
                  state_in     = S_FINISH;
               end else begin
                  // remove: kill this slot, then its mirror
                  slot_we = 1'b1;
                  slot_wa = SAW'(ptr_ff);
                  slot_wd = {1'b0, s_node, W'(0)};
                  if (!phase_ff) begin
                     wt_in        = s_w;
                     res_found_in = 1'b1;
                     if (na != nb) begin
                        phase_in = 1'b1;
                        from_in  = nb;
                        to_in    = na;
                        state_in = S_F_OFF0;
                     end else begin
                        state_in = S_REM_END;
                     end
                  end else begin
                     state_in = S_REM_END;
                  end
               end
            end
         end
         S_REM_END: begin
            if (live_ff != '0) begin
               live_in = live_ff - LCW'(1);
            end
            wsum_in  = alu_r;
            state_in = S_FINISH;
         end
         S_OF_WT: begin
            res_value_in = SW'(off_rd_ff);
            res_found_in = 1'b1;
            state_in     = S_FINISH;
         end
         S_SL_WT: begin
            res_found_in = 1'b1;
            if (s_live) begin
               res_live_in  = 1'b1;
               res_nb_in    = 8'(s_node);
               res_value_in = SW'(s_w);
            end
            state_in = S_FINISH;
         end

         // ---- reload live edges from the slots
         S_RL_ST: begin
            ptr_in   = '0;
            u_in     = '0;
            len_in   = '0;
            off_ra   = OW'(1);
            state_in = S_RL_BND;
         end
         S_RL_BND: begin
            bound_in = off_rd_ff;
            state_in = S_RL_LOOP;
         end
         S_RL_LOOP: begin
            if (ptr_ff == PW'(total_ff)) begin
               state_in = S_RL_END;
            end else if (ptr_ff == PW'(bound_ff)) begin
               u_in     = u_ff + NW'(1);
               off_ra   = OW'(u_ff) + OW'(2);
               state_in = S_RL_BND;
            end else begin
               slot_ra  = SAW'(ptr_ff);
               state_in = S_RL_CHK;
            end
         end
         S_RL_CHK: begin
            if (s_live && s_node >= u_ff) begin
               list_we = 1'b1;
               list_wa = LAW'(len_ff);
               list_wd = {u_ff, s_node, s_w};
               len_in  = len_ff + LCW'(1);
            end
            ptr_in   = ptr_ff + PW'(1);
            state_in = S_RL_LOOP;
         end
         S_RL_END: begin
            raw_in   = len_ff;
            live_in  = '0;
            wsum_in  = '0;
            built_in = 1'b0;
            state_in = S_AD_CHK0;
         end

         // ---- sorted insert with merge
         S_AD_CHK0: begin
            if (raw_ff >= LCW'(MAX_EDGES)) begin
               res_status_in = gcs_pkg::STS_FULL;
               state_in      = S_FINISH;
            end else begin
               carry_in = (na < nb) ? {na, nb, w_sat} : {nb, na, w_sat};
               ins_in   = 1'b0;
               ptr_in   = '0;
               state_in = S_AD_RD;
            end
         end
         S_AD_RD: begin
            if (ptr_ff == PW'(len_ff)) begin
               list_we  = 1'b1;
               list_wa  = LAW'(len_ff);
               list_wd  = carry_ff;
               len_in   = len_ff + LCW'(1);
               raw_in   = raw_ff + LCW'(1);
               state_in = S_FINISH;
            end else begin
               list_ra  = LAW'(ptr_ff);
               state_in = S_AD_CHK;
            end
         end
         S_AD_CHK: begin
            ptr_in   = ptr_ff + PW'(1);
            state_in = S_AD_RD;
            if (ins_ff) begin
               list_we  = 1'b1;
               list_wa  = LAW'(ptr_ff);
               list_wd  = carry_ff;
               carry_in = list_rd_ff;
            end else if ({e_u, e_v} == {c_u, c_v}) begin
               list_we  = 1'b1;
               list_wa  = LAW'(ptr_ff);
               list_wd  = {e_u, e_v, W'(alu_r)};
               raw_in   = raw_ff + LCW'(1);
               state_in = S_FINISH;
            end else if ({e_u, e_v} > {c_u, c_v}) begin
               list_we  = 1'b1;
               list_wa  = LAW'(ptr_ff);
               list_wd  = carry_ff;
               carry_in = list_rd_ff;
               ins_in   = 1'b1;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_value_in  = res_value_ff;
               rsp_nb_in     = res_nb_ff;
               rsp_live_in   = res_live_ff;
               rsp_count_in  = 11'(live_ff);
               rsp_total_in  = wsum_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= 9'd256;
         built_ff      <= 1'b0;
         raw_ff        <= '0;
         len_ff        <= '0;
         live_ff       <= '0;
         wsum_ff       <= '0;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         built_ff      <= built_in;
         raw_ff        <= raw_in;
         len_ff        <= len_in;
         live_ff       <= live_in;
         wsum_ff       <= wsum_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      idx_ff        <= idx_in;
      ptr_ff        <= ptr_in;
      bound_ff      <= bound_in;
      pfx_ff        <= pfx_in;
      u_ff          <= u_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      edge_ff       <= edge_in;
      carry_ff      <= carry_in;
      ins_ff        <= ins_in;
      phase_ff      <= phase_in;
      wt_ff         <= wt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_live_ff   <= res_live_in;
      res_value_ff  <= res_value_in;
      res_nb_ff     <= res_nb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_nb_ff     <= rsp_nb_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_neighbor     = rsp_nb_ff;
   assign rsp_slot_live    = rsp_live_ff;
   assign rsp_edge_count   = rsp_count_ff;
   assign rsp_total_weight = rsp_total_ff;

endmodule

>>> hw/rtl/gcs_sat_alu.sv
// Shared saturating add / floored subtract unit.
module gcs_sat_alu #(
   parameter int WEIGHT_BITS = gcs_pkg::WEIGHT_BITS_DEF
) (
   input  gcs_pkg::alu_req_type           req,
   output logic [gcs_pkg::SUM_W-1:0]      result
);

   localparam int SW = gcs_pkg::SUM_W;
   localparam logic [SW+1:0] WMAX = ((SW+2)'(1) << WEIGHT_BITS) - (SW+2)'(1);
   localparam logic [SW+1:0] SMAX = ((SW+2)'(1) << SW) - (SW+2)'(1);

   logic [SW+1:0] sum;
   logic [SW+1:0] diff;

   assign sum  = (SW+2)'(req.a) + (SW+2)'(req.b);
   assign diff = (SW+2)'(req.a) - (SW+2)'(req.b);

   always_comb begin
      unique case (req.op)
         gcs_pkg::ALU_ADD_W: begin
            result = (sum > WMAX) ? WMAX[SW-1:0] : sum[SW-1:0];
         end
         gcs_pkg::ALU_ADD_S: begin
            result = (sum > SMAX) ? SMAX[SW-1:0] : sum[SW-1:0];
         end
         gcs_pkg::ALU_SUB_F: begin
            result = (req.a >= req.b) ? diff[SW-1:0] : '0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

>>> verif/graph_csr_store_unit_test.sv
// Self-checking testbench for graph_csr_store_unit: queued driver, monitor and CSR store predictor.
`timescale 1ns / 1ps

module graph_csr_store_unit_test;
   import gcs_pkg::*;

   localparam int NODES = 256;
   localparam int EDGES = 1024;
   localparam int SLOTS = 2 * EDGES;
   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] WEIGHT_MAX = 32'hFFFF_FFFF;
   localparam logic [2:0] ACT_NOP_LO = 3'd6;
   localparam logic [2:0] ACT_NOP_HI = 3'd7;
   localparam int CYCLE_LIMIT = 8_000_000;

   typedef struct {
      logic [2:0]  action;
      logic [7:0]  node_a;
      logic [7:0]  node_b;
      logic [31:0] weight;
      logic [10:0] index;
   } graph_op_t;

   typedef struct {
      logic [1:0]  status;
      logic        found;
      logic [47:0] value;
      logic [7:0]  neighbor;
      logic        slot_live;
      logic [10:0] edge_count;
      logic [47:0] total_weight;
   } graph_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_node_a = '0;
   logic [7:0]  req_node_b = '0;
   logic [31:0] req_weight = '0;
   logic [10:0] req_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [47:0] rsp_value;
   logic [7:0]  rsp_neighbor;
   logic        rsp_slot_live;
   logic [10:0] rsp_edge_count;
   logic [47:0] rsp_total_weight;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_node_count = '0;

   graph_csr_store_unit dut (.*);

   always #6 clock = ~clock;

   // store model state
   logic [7:0]  pend_u [EDGES];
   logic [7:0]  pend_v [EDGES];
   logic [31:0] pend_w [EDGES];
   int          pend_n = 0;
   int          offsets [NODES + 1];
   logic [7:0]  slot_nb [SLOTS];
   logic [31:0] slot_wt [SLOTS];
   bit          slot_ok [SLOTS];
   bit          is_built = 0;
   int          live_n = 0;
   logic [47:0] wsum = '0;
   int          node_limit = 256;

   graph_op_t   op_q [$];
   graph_rsp_t  rsp_q [$];
   bit          quiet = 0;
   bit          req_fire = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   int          errors = 0;
   int          cycles = 0;
   int          n_ops = 0;
   int          n_rsps = 0;
   int          n_cfg = 0;
   int          n_full = 0;

   function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? SUM_MAX : s[47:0];
   endfunction

   function automatic void place_slot(inout int fill[NODES + 1], input int from,
                                      input logic [7:0] to, input logic [31:0] w);
      int p;
      p = fill[from];
      fill[from]++;
      if (p < SLOTS) begin
         slot_nb[p] = to;
         slot_wt[p] = w;
         slot_ok[p] = 1;
      end
   endfunction

   function automatic void build_layout();
      int n, m, i, j;
      logic [7:0] tu, tv;
      logic [31:0] tw;
      logic [32:0] s;
      int fill [NODES + 1];
      if (is_built) return;
      n = pend_n;
      // stable insertion sort on (u,v)
      for (i = 1; i < n; i++) begin
         tu = pend_u[i]; tv = pend_v[i]; tw = pend_w[i];
         j = i - 1;
         while (j >= 0 && {pend_u[j], pend_v[j]} > {tu, tv}) begin
            pend_u[j + 1] = pend_u[j]; pend_v[j + 1] = pend_v[j]; pend_w[j + 1] = pend_w[j];
            j--;
         end
         pend_u[j + 1] = tu; pend_v[j + 1] = tv; pend_w[j + 1] = tw;
      end
      m = 0;
      for (i = 0; i < n; i++) begin
         if (m > 0 && pend_u[m - 1] == pend_u[i] && pend_v[m - 1] == pend_v[i]) begin
            s = {1'b0, pend_w[m - 1]} + {1'b0, pend_w[i]};
            pend_w[m - 1] = s[32] ? WEIGHT_MAX : s[31:0];
         end else begin
            pend_u[m] = pend_u[i]; pend_v[m] = pend_v[i]; pend_w[m] = pend_w[i];
            m++;
         end
      end
      foreach (offsets[k]) offsets[k] = 0;
      wsum = '0;
      for (i = 0; i < m; i++) begin
         offsets[pend_u[i] + 1]++;
         if (pend_u[i] != pend_v[i]) offsets[pend_v[i] + 1]++;
         wsum = sat48(wsum, {16'd0, pend_w[i]});
      end
      for (i = 1; i <= NODES; i++) offsets[i] += offsets[i - 1];
      foreach (fill[k]) fill[k] = offsets[k];
      for (i = 0; i < m; i++) begin
         place_slot(fill, pend_u[i], pend_v[i], pend_w[i]);
         if (pend_u[i] != pend_v[i]) place_slot(fill, pend_v[i], pend_u[i], pend_w[i]);
      end
      live_n = m;
      pend_n = 0;
      is_built = 1;
   endfunction

   function automatic void reload_pending();
      int n, u, p;
      if (!is_built) return;
      n = 0;
      for (u = 0; u < NODES; u++)
         for (p = offsets[u]; p < offsets[u + 1] && p < SLOTS; p++)
            if (slot_ok[p] && slot_nb[p] >= u && n < EDGES) begin
               pend_u[n] = u; pend_v[n] = slot_nb[p]; pend_w[n] = slot_wt[p];
               n++;
            end
      pend_n = n;
      foreach (offsets[k]) offsets[k] = 0;
      live_n = 0;
      wsum = '0;
      is_built = 0;
   endfunction

   function automatic bit find_live(int from, logic [7:0] to, output int pos);
      int p;
      pos = 0;
      for (p = offsets[from]; p < offsets[from + 1] && p < SLOTS; p++)
         if (slot_ok[p] && slot_nb[p] == to) begin
            pos = p;
            return 1;
         end
      return 0;
   endfunction

   function automatic graph_rsp_t apply_op(graph_op_t op);
      graph_rsp_t r;
      int nc, p, q;
      logic [31:0] wt;
      bit ab_ok;
      r = '{default: '0};
      nc = node_limit > NODES ? NODES : node_limit;
      ab_ok = op.node_a < nc && op.node_b < nc;
      case (op.action)
         ACT_ADD: begin
            if (!ab_ok) r.status = STS_RANGE;
            else if (op.weight == 0) r.status = STS_ZERO;
            else begin
               reload_pending();
               if (pend_n >= EDGES) begin
                  r.status = STS_FULL;
                  n_full++;
               end else begin
                  pend_u[pend_n] = op.node_a < op.node_b ? op.node_a : op.node_b;
                  pend_v[pend_n] = op.node_a < op.node_b ? op.node_b : op.node_a;
                  pend_w[pend_n] = op.weight;
                  pend_n++;
               end
            end
         end
         ACT_REMOVE: begin
            if (!ab_ok) r.status = STS_RANGE;
            else begin
               build_layout();
               if (find_live(op.node_a, op.node_b, p)) begin
                  wt = slot_wt[p];
                  slot_ok[p] = 0; slot_wt[p] = '0;
                  if (op.node_a != op.node_b && find_live(op.node_b, op.node_a, q)) begin
                     slot_ok[q] = 0; slot_wt[q] = '0;
                  end
                  if (live_n > 0) live_n--;
                  wsum = wsum >= wt ? wsum - wt : '0;
                  r.found = 1;
               end
            end
         end
         ACT_WEIGHT: begin
            if (!ab_ok) r.status = STS_RANGE;
            else begin
               build_layout();
               if (find_live(op.node_a, op.node_b, p)) begin
                  r.value = slot_wt[p];
                  r.found = 1;
               end
            end
         end
         ACT_DEGREE: begin
            if (op.node_a >= nc) r.status = STS_RANGE;
            else begin
               build_layout();
               for (p = offsets[op.node_a]; p < offsets[op.node_a + 1] && p < SLOTS; p++)
                  if (slot_ok[p])
                     r.value = sat48(r.value, slot_nb[p] == op.node_a ?
                                     {15'd0, slot_wt[p], 1'b0} : {16'd0, slot_wt[p]});
            end
         end
         ACT_OFFSET: begin
            if (op.index > nc) r.status = STS_RANGE;
            else begin
               build_layout();
               r.value = offsets[op.index];
               r.found = 1;
            end
         end
         ACT_SLOT: begin
            build_layout();
            if (op.index < offsets[NODES]) begin
               r.found = 1;
               if (slot_ok[op.index]) begin
                  r.slot_live = 1;
                  r.neighbor = slot_nb[op.index];
                  r.value = slot_wt[op.index];
               end
            end
         end
         default: ;
      endcase
      r.edge_count = live_n;
      r.total_weight = wsum;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            req_gap = $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (op_q.size() > 0) begin
            graph_op_t op;
            op = op_q.pop_front();
            req_valid <= 1'b1;
            req_action <= op.action;
            req_node_a <= op.node_a;
            req_node_b <= op.node_b;
            req_weight <= op.weight;
            req_index <= op.index;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check responses, then predict for the accepted item
   always @(posedge clock) begin
      graph_op_t op;
      graph_rsp_t e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            node_limit = csr_node_count;
            n_cfg++;
         end
         if (rsp_valid && rsp_ready) begin
            n_rsps++;
            if (rsp_q.size() == 0) begin
               $error("response item with nothing expected");
               errors++;
            end else begin
               e = rsp_q.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++;
               end
               if (rsp_found !== e.found) begin
                  $error("found exp %0d got %0d", e.found, rsp_found); errors++;
               end
               if (rsp_value !== e.value) begin
                  $error("value exp %h got %h", e.value, rsp_value); errors++;
               end
               if (rsp_neighbor !== e.neighbor) begin
                  $error("neighbor exp %0d got %0d", e.neighbor, rsp_neighbor); errors++;
               end
               if (rsp_slot_live !== e.slot_live) begin
                  $error("slot_live exp %0d got %0d", e.slot_live, rsp_slot_live); errors++;
               end
               if (rsp_edge_count !== e.edge_count) begin
                  $error("edge_count exp %0d got %0d", e.edge_count, rsp_edge_count);
                  errors++;
               end
               if (rsp_total_weight !== e.total_weight) begin
                  $error("total_weight exp %h got %h", e.total_weight, rsp_total_weight);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            op = '{req_action, req_node_a, req_node_b, req_weight, req_index};
            rsp_q.push_back(apply_op(op));
            n_ops++;
         end
      end
   end

   task automatic push_op(logic [2:0] act, logic [7:0] a, logic [7:0] b,
                          logic [31:0] w, logic [10:0] idx);
      op_q.push_back('{act, a, b, w, idx});
   endtask

   task automatic wait_drained();
      while (op_q.size() > 0 || req_valid || rsp_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_nodes(logic [8:0] v);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_node_count <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_node(int nc);
      if (nc < NODES && $urandom_range(0, 19) == 0) return $urandom_range(0, 255);
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, (nc < 12 ? nc : 12) - 1);
      return $urandom_range(0, nc - 1);
   endfunction

   task automatic push_random(int count);
      int nc, r;
      logic [2:0] act;
      logic [31:0] w;
      logic [10:0] idx;
      nc = node_limit > NODES ? NODES : node_limit;
      repeat (count) begin
         r = $urandom_range(0, 99);
         act = r < 35 ? ACT_ADD : r < 50 ? ACT_REMOVE : r < 63 ? ACT_WEIGHT :
               r < 73 ? ACT_DEGREE : r < 83 ? ACT_OFFSET : r < 93 ? ACT_SLOT :
               (r[0] ? ACT_NOP_HI : ACT_NOP_LO);
         case ($urandom_range(0, 15))
            0:       w = '0;
            1, 2:    w = WEIGHT_MAX;
            3, 4, 5: w = $urandom;
            default: w = $urandom_range(1, 32'h0004_0000);
         endcase
         if ($urandom_range(0, 7) == 0) idx = $urandom;
         else if (act == ACT_OFFSET) idx = $urandom_range(0, nc + 1);
         else idx = $urandom_range(0, 40);
         push_op(act, pick_node(nc), pick_node(nc), w, idx);
      end
   endtask

   initial begin
      int i, u;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, self-loop, duplicate merge, dead slots, reload
      push_op(ACT_DEGREE, 8'd0, 8'd0, '0, '0);          // query on empty store
      push_op(ACT_ADD, 8'd0, 8'd255, WEIGHT_MAX, '0);
      push_op(ACT_ADD, 8'd255, 8'd0, WEIGHT_MAX, '0);   // duplicate saturates
      push_op(ACT_ADD, 8'd5, 8'd5, 32'h0001_8000, '0);  // self-loop
      push_op(ACT_ADD, 8'd3, 8'd9, 32'd0, '0);          // zero weight
      push_op(ACT_ADD, 8'd9, 8'd3, 32'h0000_0001, '0);
      push_op(ACT_WEIGHT, 8'd255, 8'd0, '0, '0);
      push_op(ACT_DEGREE, 8'd5, 8'hAA, '0, '0);
      push_op(ACT_DEGREE, 8'd0, 8'd0, '0, '0);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd0);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd256);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd257);
      push_op(ACT_SLOT, '0, '0, '0, 11'd0);
      push_op(ACT_SLOT, '0, '0, '0, 11'd2047);
      push_op(ACT_REMOVE, 8'd255, 8'd0, '0, '0);
      push_op(ACT_REMOVE, 8'd0, 8'd255, '0, '0);        // already gone
      push_op(ACT_SLOT, '0, '0, '0, 11'd0);             // dead slot
      push_op(ACT_NOP_LO, 8'hFF, 8'hFF, WEIGHT_MAX, 11'h7FF);
      push_op(ACT_NOP_HI, '0, '0, '0, '0);
      push_op(ACT_ADD, 8'd7, 8'd2, 32'h8000_0000, '0);  // reload after build
      push_op(ACT_WEIGHT, 8'd3, 8'd9, '0, '0);
      push_op(ACT_DEGREE, 8'd9, '0, '0, '0);

      write_nodes(9'd1);
      push_op(ACT_ADD, 8'd0, 8'd1, 32'd4, '0);
      push_op(ACT_ADD, 8'd0, 8'd0, 32'd0, '0);
      push_op(ACT_DEGREE, 8'd1, '0, '0, '0);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd1);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd2);
      push_op(ACT_REMOVE, 8'd0, 8'd0, '0, '0);

      write_nodes(9'd6);   push_random(130);
      write_nodes(9'd256); push_random(140);
      write_nodes(9'd511); quiet = 1; push_random(120);
      write_nodes(9'd13);  quiet = 0; push_random(130);
      write_nodes(9'd2);   push_random(100);
      write_nodes(9'd200); push_random(130);

      // final stretch without idling: fill the pending store past capacity
      write_nodes(9'd256);
      quiet = 1;
      for (i = 0; i < EDGES + 6; i++) begin
         u = 16 + i / 8;
         push_op(ACT_ADD, u, u + i % 8, $urandom | 32'd1, '0);
      end
      push_op(ACT_DEGREE, 8'd16, '0, '0, '0);
      push_op(ACT_OFFSET, '0, '0, '0, 11'd256);
      push_op(ACT_SLOT, '0, '0, '0, 11'd2047);
      push_op(ACT_WEIGHT, 8'd20, 8'd23, '0, '0);
      push_op(ACT_REMOVE, 8'd17, 8'd17, '0, '0);
      push_op(ACT_DEGREE, 8'd17, '0, '0, '0);
      wait_drained();
      repeat (100) @(posedge clock);

      $display("ran %0d items, %0d responses, %0d node_count writes", n_ops, n_rsps, n_cfg);
      $display("pending store rejected %0d adds as full, %0d mismatches", n_full, errors);
      if (errors == 0 && rsp_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
